// ----- design/ssqc_pkg.sv -----
// ----------------------------------------------------------------------------
// ssqc_pkg
// Shared types and constants of the sample quality checker: register
// indexes, per-channel history entry and the result word.
// ----------------------------------------------------------------------------
package ssqc_pkg;

    // result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;
    localparam logic [FIFO_CNT_W-1:0] FIFO_FULL = FIFO_CNT_W'(FIFO_DEPTH);

    // configuration register indexes
    localparam logic [2:0] REG_MAX_AGE      = 3'd0;
    localparam logic [2:0] REG_QUALITY_MASK = 3'd1;
    localparam logic [2:0] REG_VALUE_MIN    = 3'd2;
    localparam logic [2:0] REG_VALUE_MAX    = 3'd3;
    localparam logic [2:0] REG_SENTINEL     = 3'd4;
    localparam logic [2:0] REG_MAX_GAP      = 3'd5;
    localparam logic [2:0] REG_MAX_RATE     = 3'd6;
    localparam logic [2:0] REG_FROZEN_AFTER = 3'd7;

    typedef struct packed {
        logic [7:0] channel;
        logic       stale;
        logic       quality_reject;
        logic       range_fault;
        logic       sentinel_hit;
        logic       time_backwards;
        logic       samples_missing;
        logic       rate_exceeded;
        logic       frozen_value;
    } result_t;

    typedef struct packed {
        logic signed [31:0] last_value;
        logic [39:0]        last_time;
        logic [39:0]        hold_start;
    } hist_t;

endpackage

// ----- design/ssqc_result_fifo.sv -----
// ----------------------------------------------------------------------------
// ssqc_result_fifo
// Small result queue between the check pipeline and the output channel.
// The top level never pushes into a full queue.
// ----------------------------------------------------------------------------
module ssqc_result_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ssqc_pkg::result_t push_data,
    input  logic              pop,
    output ssqc_pkg::result_t head,
    output logic              not_empty
);

    ssqc_pkg::result_t                  entry_reg [ssqc_pkg::FIFO_DEPTH];
    logic [ssqc_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [ssqc_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [ssqc_pkg::FIFO_CNT_W-1:0]    count_reg;
    logic [ssqc_pkg::FIFO_CNT_W-1:0]    count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);

endmodule

// ----- design/signal_sample_quality_checker.sv -----
// ----------------------------------------------------------------------------
// signal_sample_quality_checker
// Checks each sample word against shared rules and against the history of
// its channel, which lives in one synchronous memory.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  channel, sample_value,
//                                             quality_code, sample_time,
//                                             now_time
//   output    out        out_valid/out_stall  out_channel and eight flags
//   config    in         cfg_we               cfg_index, cfg_data
//
// One word per cycle while in_stall is low; a result passes the check stage, the rate stage and the result queue.
// History is read at accept and written back in the next cycle; a forwarding
// register covers a back-to-back hit on the same channel.
// in_stall rises when four words are in flight or queued, so a stalled
// output backs up into the input after at most four words.
// Reset clears the seen bits and sets the rules to their defaults at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module signal_sample_quality_checker
#(
    parameter int CHANNELS       = 256,
    parameter int HOLD_TOLERANCE = 0
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         channel,
    input  logic signed [31:0] sample_value,
    input  logic [3:0]         quality_code,
    input  logic [39:0]        sample_time,
    input  logic [39:0]        now_time,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_channel,
    output logic               stale,
    output logic               quality_reject,
    output logic               range_fault,
    output logic               sentinel_hit,
    output logic               time_backwards,
    output logic               samples_missing,
    output logic               rate_exceeded,
    output logic               frozen_value,

    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int DEPTH = (CHANNELS < 256) ? CHANNELS : 256;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // rules
    logic [31:0]        max_age_reg;
    logic [15:0]        quality_mask_reg;
    logic signed [31:0] value_min_reg;
    logic signed [31:0] value_max_reg;
    logic signed [31:0] sentinel_reg;
    logic [31:0]        max_gap_reg;
    logic [31:0]        max_rate_reg;
    logic [31:0]        frozen_after_reg;

    logic                             in_accept;
    logic                             out_accept;
    logic [IDX_W-1:0]                 in_idx;
    logic [ssqc_pkg::FIFO_CNT_W-1:0]  inflight_reg;
    logic [ssqc_pkg::FIFO_CNT_W-1:0]  inflight_next;

    // history store
    ssqc_pkg::hist_t  hist_mem [DEPTH];
    ssqc_pkg::hist_t  rd_data_reg;
    logic [DEPTH-1:0] seen_reg;

    // check stage
    logic               s1_valid_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [7:0]         s1_channel_reg;
    logic signed [31:0] s1_value_reg;
    logic [3:0]         s1_quality_reg;
    logic [39:0]        s1_time_reg;
    logic [39:0]        s1_now_reg;

    logic               fwd_valid_reg;
    logic [IDX_W-1:0]   fwd_idx_reg;
    ssqc_pkg::hist_t    fwd_data_reg;

    ssqc_pkg::hist_t    hist_cur;
    ssqc_pkg::hist_t    wr_data;
    ssqc_pkg::result_t  s1_res;
    logic               seen_cur;
    logic [40:0]        dt;
    logic [32:0]        dv;
    logic [32:0]        abs_dv;
    logic [40:0]        age;
    logic [40:0]        ss_diff;
    logic               value_moved;
    logic               store;
    logic               rate_chk;

    // rate stage
    logic               s2_valid_reg;
    ssqc_pkg::result_t  s2_res_reg;
    logic               s2_chk_reg;
    logic [42:0]        s2_lhs_reg;
    logic [51:0]        s2_pp_lo_reg;
    logic [51:0]        s2_pp_hi_reg;
    logic [71:0]        rate_prod;
    ssqc_pkg::result_t  push_data;
    ssqc_pkg::result_t  head;
    logic               fifo_not_empty;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_age_reg      <= 32'hFFFF_FFFF;
            quality_mask_reg <= 16'hFFFF;
            value_min_reg    <= 32'sh8000_0000;
            value_max_reg    <= 32'sh7FFF_FFFF;
            sentinel_reg     <= 32'sh8000_0000;
            max_gap_reg      <= '0;
            max_rate_reg     <= '0;
            frozen_after_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ssqc_pkg::REG_MAX_AGE:      max_age_reg      <= cfg_data;
                ssqc_pkg::REG_QUALITY_MASK: quality_mask_reg <= cfg_data[15:0];
                ssqc_pkg::REG_VALUE_MIN:    value_min_reg    <= cfg_data;
                ssqc_pkg::REG_VALUE_MAX:    value_max_reg    <= cfg_data;
                ssqc_pkg::REG_SENTINEL:     sentinel_reg     <= cfg_data;
                ssqc_pkg::REG_MAX_GAP:      max_gap_reg      <= cfg_data;
                ssqc_pkg::REG_MAX_RATE:     max_rate_reg     <= cfg_data;
                ssqc_pkg::REG_FROZEN_AFTER: frozen_after_reg <= cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input side and flow control
    // ------------------------------------------------------------------
    assign in_stall   = (inflight_reg == ssqc_pkg::FIFO_FULL);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;

    always_comb
    begin
        inflight_next = inflight_reg;
        unique case ({in_accept, out_accept})
            2'b10:   inflight_next = inflight_reg + 1'b1;
            2'b01:   inflight_next = inflight_reg - 1'b1;
            default: inflight_next = inflight_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // channel folded onto the history depth
    generate
        if (CHANNELS >= 256)
        begin : g_idx_direct
            assign in_idx = channel;
        end
        else
        begin : g_idx_fold
            logic [15:0] rem;
            always_comb
            begin
                rem = {8'd0, channel};
                for (int k = 7; k >= 0; k--)
                begin
                    if (rem >= (16'(CHANNELS) << k))
                    begin
                        rem = rem - (16'(CHANNELS) << k);
                    end
                end
            end
            assign in_idx = rem[IDX_W-1:0];
        end
    endgenerate

    // ------------------------------------------------------------------
    // history memory: read at accept, written back from the check stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            hist_mem[s1_idx_reg] <= wr_data;
        end
        rd_data_reg <= hist_mem[in_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_valid_reg)
            begin
                seen_reg[s1_idx_reg] <= 1'b1;
            end
            s1_valid_reg  <= in_accept;
            fwd_valid_reg <= s1_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_idx_reg     <= in_idx;
            s1_channel_reg <= channel;
            s1_value_reg   <= sample_value;
            s1_quality_reg <= quality_code;
            s1_time_reg    <= sample_time;
            s1_now_reg     <= now_time;
        end
        fwd_idx_reg  <= s1_idx_reg;
        fwd_data_reg <= wr_data;
    end

    // ------------------------------------------------------------------
    // check stage
    // ------------------------------------------------------------------
    always_comb
    begin
        // memory read missed the write done at the same edge
        if (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg))
        begin
            hist_cur = fwd_data_reg;
        end
        else
        begin
            hist_cur = rd_data_reg;
        end

        seen_cur    = seen_reg[s1_idx_reg];
        dt          = {1'b0, s1_time_reg} - {1'b0, hist_cur.last_time};
        dv          = {s1_value_reg[31], s1_value_reg}
                    - {hist_cur.last_value[31], hist_cur.last_value};
        abs_dv      = dv[32] ? (33'd0 - dv) : dv;
        age         = {1'b0, s1_now_reg} - {1'b0, s1_time_reg};
        ss_diff     = {1'b0, s1_time_reg} - {1'b0, hist_cur.hold_start};
        value_moved = (abs_dv > 33'(HOLD_TOLERANCE));
        store       = !seen_cur || !dt[40];
        rate_chk    = seen_cur && !dt[40] && (dt != '0) && (max_rate_reg != '0);

        s1_res.channel         = s1_channel_reg;
        s1_res.stale           = !age[40] && (age[39:0] > {8'd0, max_age_reg});
        s1_res.quality_reject  = !quality_mask_reg[s1_quality_reg];
        s1_res.range_fault     = (s1_value_reg < value_min_reg)
                              || (s1_value_reg > value_max_reg);
        s1_res.sentinel_hit    = (s1_value_reg == sentinel_reg);
        s1_res.time_backwards  = seen_cur && dt[40];
        s1_res.samples_missing = seen_cur && (max_gap_reg != '0) && !dt[40]
                              && (dt[39:0] > {8'd0, max_gap_reg});
        s1_res.rate_exceeded   = 1'b0;
        // a moved value restarts the stable window, so it cannot be frozen
        s1_res.frozen_value    = seen_cur && (frozen_after_reg != '0) && !value_moved
                              && !ss_diff[40]
                              && (ss_diff[39:0] >= {8'd0, frozen_after_reg});

        wr_data.last_value = store ? s1_value_reg : hist_cur.last_value;
        wr_data.last_time  = store ? s1_time_reg  : hist_cur.last_time;
        wr_data.hold_start = (!seen_cur || value_moved) ? s1_time_reg
                                                        : hist_cur.hold_start;
    end

    // ------------------------------------------------------------------
    // rate stage: |dv| * 1000 against max_rate * dt in two partial products
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        s2_res_reg   <= s1_res;
        s2_chk_reg   <= rate_chk;
        s2_lhs_reg   <= {10'd0, abs_dv} * 43'd1000;
        s2_pp_lo_reg <= {20'd0, max_rate_reg} * {32'd0, dt[19:0]};
        s2_pp_hi_reg <= {20'd0, max_rate_reg} * {32'd0, dt[39:20]};
    end

    // a product past 64 bits never loses to the left side
    assign rate_prod = {s2_pp_hi_reg, 20'd0} + {20'd0, s2_pp_lo_reg};

    always_comb
    begin
        push_data               = s2_res_reg;
        push_data.rate_exceeded = s2_chk_reg && ({29'd0, s2_lhs_reg} > rate_prod);
    end

    ssqc_result_fifo u_result_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (push_data),
        .pop       (out_accept),
        .head      (head),
        .not_empty (fifo_not_empty)
    );

    assign out_valid       = fifo_not_empty;
    assign out_channel     = head.channel;
    assign stale           = head.stale;
    assign quality_reject  = head.quality_reject;
    assign range_fault     = head.range_fault;
    assign sentinel_hit    = head.sentinel_hit;
    assign time_backwards  = head.time_backwards;
    assign samples_missing = head.samples_missing;
    assign rate_exceeded   = head.rate_exceeded;
    assign frozen_value    = head.frozen_value;

endmodule
